// ===== rtl/kds_pkg.sv =====
// ----------------------------------------------------------------------------
// kds_pkg: shared definitions for the keyed deque store
// Field widths, command and status codes, and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package kds_pkg;

  // Field widths of one input item and one result item.
  localparam int CMD_W    = 3;
  localparam int ID_W     = 16;
  localparam int PRICE_W  = 24;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  // Default number of slots in the ring.
  localparam int DEF_STORE_DEPTH = 16;

  // Stream data widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = CMD_W + ID_W + PRICE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + ID_W + PRICE_W + ENTRY_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd5;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PUSH_TAIL,
    DP_PUSH_HEAD,
    DP_POP_FRONT,
    DP_POP_BACK,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_OUTPUT
  } dp_op_e;

  // Controller to datapath.
  typedef struct packed {
    dp_op_e  op;
    logic    set_res;
    status_e res_status;
    logic    take_found;
    logic    write_price;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             match;
    logic             last;
  } dp_stat_t;

endpackage

// ===== rtl/keyed_deque_store_core.sv =====
// ----------------------------------------------------------------------------
// keyed_deque_store_core: bounded double-ended store of (id, price) entries
//
// One command enters on the slave stream: push tail, push head, pop front,
// pop back, search by id or update price by id. Every command gives exactly
// one result transaction on the master stream with status, the found id and
// price (search hits only) and the entry count after the command.
// Entries sit in a ring held in one RAM with registered read.
//
// Timing: one command is worked on at a time. A push, pop, empty, full or
// unused command passes the execute and response steps; its result is then
// written to the output register, and the next command can be accepted.
// Search and update read the ring from the front one entry per cycle through
// the RAM read port, in a scan step between execute and response that stops
// at the first match or after the last held entry.
// The output register lets the next command be accepted while a result is
// still waiting; if the receiver stalls, the following result holds the
// block in its response step until the register frees up.
// Reset empties the store at once (front and count to zero); the RAM is not
// cleared, as only entries written by a push are ever read.
// ----------------------------------------------------------------------------
module keyed_deque_store_core
  import kds_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Fields from bit 0: command[2:0], item_id[18:3], item_price[42:19], zero pad.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: status[1:0], found_id[17:2], found_price[41:18],
  // entry_count[46:42], zero pad.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  localparam int IdLo    = CMD_W;
  localparam int PriceLo = CMD_W + ID_W;

  ctrl_cmd_t           ctrl_cmd;
  dp_stat_t            dp_stat;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic [PRICE_W-1:0]  out_price;
  logic [ENTRY_W-1:0]  out_count;

  // Command sequencing.
  kds_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd)
  );

  // Storage and scan.
  kds_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tdata[CMD_W-1:0]),
    .in_id_i      (s_axis_tdata[IdLo +: ID_W]),
    .in_price_i   (s_axis_tdata[PriceLo +: PRICE_W]),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .out_status_o (out_status),
    .out_id_o     (out_id),
    .out_price_o  (out_price),
    .out_count_o  (out_count)
  );

  // Result packing.
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_price, out_id, out_status};

endmodule

// ===== rtl/kds_ram.sv =====
// ----------------------------------------------------------------------------
// kds_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module kds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kds_ctrl.sv =====
// ----------------------------------------------------------------------------
// kds_ctrl: controller of the keyed deque store
// Sequences one command at a time through execute, scan and response, and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module kds_ctrl
  import kds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d           = state_q;
    out_valid_d       = out_valid_q && !m_ready_i;
    cmd_o             = '0;
    cmd_o.op          = DP_NONE;
    cmd_o.res_status  = ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.set_res = 1'b1;
        state_d       = S_RESP;
        case (stat_i.cmd)
          CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.op = (stat_i.cmd == CMD_PUSH_TAIL) ? DP_PUSH_TAIL : DP_PUSH_HEAD;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.op = (stat_i.cmd == CMD_POP_FRONT) ? DP_POP_FRONT : DP_POP_BACK;
            end
          end
          CMD_SEARCH, CMD_UPDATE: begin
            if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.set_res = 1'b0;
              cmd_o.op      = DP_SCAN_START;
              state_d       = S_SCAN;
            end
          end
          default: begin
            // Unused codes leave the store as it is.
            cmd_o.res_status = ST_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.op = DP_SCAN_STEP;
        if (stat_i.match) begin
          cmd_o.set_res     = 1'b1;
          cmd_o.take_found  = (stat_i.cmd == CMD_SEARCH);
          cmd_o.write_price = (stat_i.cmd == CMD_UPDATE);
          state_d           = S_RESP;
        end else if (stat_i.last) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.op    = DP_OUTPUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/kds_datapath.sv =====
// ----------------------------------------------------------------------------
// kds_datapath: ring storage and scan datapath of the keyed deque store
// Holds the command registers, front index, count, scan pointer, entry RAM,
// result registers and the output register.
// ----------------------------------------------------------------------------
module kds_datapath
  import kds_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CMD_W-1:0]   in_cmd_i,
  input  logic [ID_W-1:0]    in_id_i,
  input  logic [PRICE_W-1:0] in_price_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [ID_W-1:0]    out_id_o,
  output logic [PRICE_W-1:0] out_price_o,
  output logic [ENTRY_W-1:0] out_count_o
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int WORD_W = ID_W + PRICE_W;

  localparam logic [IDX_W-1:0] LastSlot = IDX_W'(STORE_DEPTH - 1);
  localparam logic [IDX_W:0]   DepthL   = (IDX_W + 1)'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(STORE_DEPTH);

  logic [CMD_W-1:0]    cmd_q;
  logic [ID_W-1:0]     key_q;
  logic [PRICE_W-1:0]  price_q;
  logic [IDX_W-1:0]    front_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    cur_slot_q;
  logic [IDX_W-1:0]    cur_k_q;
  status_e             res_status_q;
  logic [ID_W-1:0]     found_id_q;
  logic [PRICE_W-1:0]  found_price_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ID_W-1:0]     out_id_q;
  logic [PRICE_W-1:0]  out_price_q;
  logic [ENTRY_W-1:0]  out_count_q;

  logic [IDX_W-1:0]  front_inc, front_dec, cur_inc, tail_slot;
  logic [IDX_W:0]    tail_sum;
  logic              is_push;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [ID_W-1:0]   rd_id;
  logic [PRICE_W-1:0] rd_price;

  // Ring index arithmetic, wrapping at the store depth.
  assign front_inc = (front_q == LastSlot) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastSlot : front_q - 1'b1;
  assign cur_inc   = (cur_slot_q == LastSlot) ? '0 : cur_slot_q + 1'b1;
  assign tail_sum  = {1'b0, front_q} + (IDX_W + 1)'(count_q);
  assign tail_slot = (tail_sum >= DepthL) ? IDX_W'(tail_sum - DepthL) : IDX_W'(tail_sum);

  // RAM ports: pushes and price updates write, the scan reads ahead.
  assign is_push   = (cmd_i.op == DP_PUSH_TAIL) || (cmd_i.op == DP_PUSH_HEAD);
  assign ram_we    = is_push || cmd_i.write_price;
  assign ram_waddr = cmd_i.write_price         ? cur_slot_q :
                     (cmd_i.op == DP_PUSH_HEAD) ? front_dec  : tail_slot;
  assign ram_raddr = (cmd_i.op == DP_SCAN_STEP) ? cur_inc : front_q;

  kds_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, price_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_id    = ram_rdata[WORD_W-1:PRICE_W];
  assign rd_price = ram_rdata[PRICE_W-1:0];

  // Status toward the controller.
  assign stat_o.cmd   = cmd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.match = (rd_id == key_q);
  assign stat_o.last  = ((CNT_W'(cur_k_q) + CNT_W'(1)) == count_q);

  // Ring control state and scan pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      cur_slot_q <= '0;
      cur_k_q    <= '0;
    end else begin
      case (cmd_i.op)
        DP_PUSH_TAIL: begin
          count_q <= count_q + 1'b1;
        end
        DP_PUSH_HEAD: begin
          front_q <= front_dec;
          count_q <= count_q + 1'b1;
        end
        DP_POP_FRONT: begin
          front_q <= front_inc;
          count_q <= count_q - 1'b1;
        end
        DP_POP_BACK: begin
          count_q <= count_q - 1'b1;
        end
        DP_SCAN_START: begin
          cur_slot_q <= front_q;
          cur_k_q    <= '0;
        end
        DP_SCAN_STEP: begin
          cur_slot_q <= cur_inc;
          cur_k_q    <= cur_k_q + 1'b1;
        end
        default: begin
          cur_k_q <= cur_k_q;
        end
      endcase
    end
  end

  // Command, result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      cmd_q   <= in_cmd_i;
      key_q   <= in_id_i;
      price_q <= in_price_i;
    end
    if (cmd_i.set_res) begin
      res_status_q  <= cmd_i.res_status;
      found_id_q    <= cmd_i.take_found ? rd_id : '0;
      found_price_q <= cmd_i.take_found ? rd_price : '0;
    end
    if (cmd_i.op == DP_OUTPUT) begin
      out_status_q <= res_status_q;
      out_id_q     <= found_id_q;
      out_price_q  <= found_price_q;
      out_count_q  <= ENTRY_W'(count_q);
    end
  end

  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_price_o  = out_price_q;
  assign out_count_o  = out_count_q;

  // The count never passes the depth and the front stays inside the ring.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("entry count above store depth");

  a_front_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < DepthL) else $error("front index outside ring");

  // A push is only issued with room left, a pop only with an entry held.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_push |-> (count_q != FullCnt)) else $error("push issued on full store");

  a_pop_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == DP_POP_FRONT) || (cmd_i.op == DP_POP_BACK)) |-> (count_q != '0))
    else $error("pop issued on empty store");

  // The scan never compares an entry beyond the held ones.
  a_scan_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_SCAN_STEP) |-> (CNT_W'(cur_k_q) < count_q))
    else $error("scan ran past held entries");

endmodule

// ===== verif/keyed_deque_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_deque_store_core_tb: self-checking bench for the keyed deque store
// Sends push, pop, search, update and unused commands on the slave stream and
// checks every result transaction against a behavioral copy of the ring kept
// in the bench. Both streams idle at random, and once the receiver stalls
// long enough to back the block up.
// ----------------------------------------------------------------------------
module keyed_deque_store_core_tb;
  import kds_pkg::*;

  localparam int DEPTH      = DEF_STORE_DEPTH;
  localparam int RAND_CMDS  = 1800;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int CALM_TAIL  = 150;

  // Codes that the block ignores.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    bit                 drain_first;
  } store_cmd_t;

  typedef struct {
    status_e            status;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [ENTRY_W-1:0] count;
  } store_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  keyed_deque_store_core #(.STORE_DEPTH(DEPTH)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting to be sent and replies waiting to arrive.
  store_cmd_t   cmds_to_send[$];
  store_reply_t replies_due[$];

  // Bench copy of the ring.
  logic [ID_W-1:0]    ring_id[DEPTH];
  logic [PRICE_W-1:0] ring_price[DEPTH];
  int                 front_slot = 0;
  int                 held_entries = 0;

  int fail_count = 0;
  int cmds_taken = 0;
  int replies_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit in_taken = 1'b0;
  int stall_cycles = 0;
  logic [ID_W-1:0] key_pool[8];

  // Apply one command to the bench ring and return the reply it must give.
  function automatic store_reply_t predict_reply(store_cmd_t c);
    store_reply_t r;
    int slot;
    int hit;
    int k;
    r.status = ST_DONE;
    r.id     = '0;
    r.price  = '0;
    case (c.cmd)
      CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
        if (held_entries >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.cmd == CMD_PUSH_TAIL) begin
            slot = (front_slot + held_entries) % DEPTH;
          end else begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            slot = front_slot;
          end
          ring_id[slot]    = c.id;
          ring_price[slot] = c.price;
          held_entries++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (held_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.cmd == CMD_POP_FRONT) front_slot = (front_slot + 1) % DEPTH;
          held_entries--;
        end
      end
      CMD_SEARCH, CMD_UPDATE: begin
        if (held_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The first match from the front wins.
          hit = -1;
          for (k = 0; k < held_entries; k++) begin
            if (hit < 0 && ring_id[(front_slot + k) % DEPTH] == c.id) hit = k;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            slot = (front_slot + hit) % DEPTH;
            if (c.cmd == CMD_SEARCH) begin
              r.id    = ring_id[slot];
              r.price = ring_price[slot];
            end else begin
              ring_price[slot] = c.price;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.count = ENTRY_W'(held_entries);
    return r;
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                         logic [PRICE_W-1:0] price, bit drain_first);
    store_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.price = price;
    c.drain_first = drain_first;
    cmds_to_send.push_back(c);
  endtask

  // Keys come mostly from a small pool so that duplicates and hits are common.
  function automatic logic [ID_W-1:0] pick_key(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, 7)];
    return ID_W'($urandom());
  endfunction

  // Acceptance on both streams, prediction and result checking.
  always @(posedge clk_i) begin
    store_reply_t want;
    store_reply_t got;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      replies_due.push_back(predict_reply(cmds_to_send.pop_front()));
      cmds_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tdata[0 +: STATUS_W]);
      got.id     = m_axis_tdata[STATUS_W +: ID_W];
      got.price  = m_axis_tdata[STATUS_W + ID_W +: PRICE_W];
      got.count  = m_axis_tdata[STATUS_W + ID_W + PRICE_W +: ENTRY_W];
      replies_seen++;
      if (replies_due.size() == 0) begin
        $error("Result transaction with no command outstanding: 0x%h", m_axis_tdata);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        status_seen[want.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.id !== want.id) begin
          $error("found_id: expected 0x%h, got 0x%h", want.id, got.id);
          fail_count++;
        end
        if (got.price !== want.price) begin
          $error("found_price: expected 0x%h, got 0x%h", want.price, got.price);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, got.count);
          fail_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0) begin
          $error("pad: expected 0, got 0x%h", m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
          fail_count++;
        end
      end
    end
  end

  // Command driver: random gaps, a pause for a full drain where asked.
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (cmds_to_send.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (cmds_to_send[0].drain_first && replies_due.size() != 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (cmds_to_send.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      src_gap = $urandom_range(1, 16) - 1;
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                        cmds_to_send[0].price, cmds_to_send[0].id, cmds_to_send[0].cmd};
    end
  end

  // Result receiver: random stalls, plus one long hold-off to back the block up.
  int sink_gap = 0;
  int sink_hold = 0;
  bit long_hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && cmds_taken >= 400) begin
      long_hold_done = 1'b1;
      sink_hold = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (cmds_to_send.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
      sink_gap = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: too long with no transaction on either stream ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int made;
    int run_len;
    int mode;
    int r;
    int i;
    logic [CMD_W-1:0] op;

    foreach (key_pool[i]) key_pool[i] = ID_W'($urandom());

    // Directed: every command on an empty store, field extremes, duplicates.
    add_cmd(CMD_POP_FRONT, 16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_POP_BACK,  16'hFFFF, 24'hFFFFFF, 1'b0);
    add_cmd(CMD_SEARCH,    16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_UPDATE,    16'hFFFF, 24'hFFFFFF, 1'b0);
    add_cmd(CMD_SPARE_A,   16'hFFFF, 24'hFFFFFF, 1'b0);
    add_cmd(CMD_SPARE_B,   16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_PUSH_TAIL, 16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_PUSH_HEAD, 16'hFFFF, 24'hFFFFFF, 1'b0);
    add_cmd(CMD_PUSH_TAIL, 16'h1234, 24'h000001, 1'b0);
    add_cmd(CMD_PUSH_TAIL, 16'hFFFF, 24'h000005, 1'b0);
    add_cmd(CMD_SEARCH,    16'hFFFF, 24'h000000, 1'b0);
    add_cmd(CMD_SEARCH,    16'h0000, 24'hFFFFFF, 1'b0);
    add_cmd(CMD_SEARCH,    16'hBEEF, 24'h000000, 1'b0);
    add_cmd(CMD_UPDATE,    16'hFFFF, 24'hABCDEF, 1'b0);
    add_cmd(CMD_SEARCH,    16'hFFFF, 24'h000000, 1'b0);
    add_cmd(CMD_UPDATE,    16'h4321, 24'h123456, 1'b0);
    add_cmd(CMD_SPARE_B,   16'h1234, 24'h00FF00, 1'b0);
    add_cmd(CMD_POP_FRONT, 16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_POP_BACK,  16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_SEARCH,    16'hFFFF, 24'h000000, 1'b0);
    add_cmd(CMD_POP_FRONT, 16'h0000, 24'h000000, 1'b0);
    add_cmd(CMD_POP_BACK,  16'h0000, 24'h000000, 1'b0);

    // Fill past the brim after a full drain, then look up what went in.
    for (i = 0; i < DEPTH + 3; i++) begin
      add_cmd(($urandom_range(0, 1) != 0) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL,
              pick_key(70), PRICE_W'($urandom()), i == 0);
    end
    for (i = 0; i < 8; i++) begin
      add_cmd(($urandom_range(0, 1) != 0) ? CMD_SEARCH : CMD_UPDATE,
              pick_key(90), PRICE_W'($urandom()), 1'b0);
    end

    // Random phases that lean toward filling, draining or neither.
    made = DEPTH + 11;
    while (made < RAND_CMDS) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(20, 60);
      for (i = 0; i < run_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < ((mode == 0) ? 60 : (mode == 1) ? 20 : 35)) begin
          op = ($urandom_range(0, 1) != 0) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
        end else if (r < ((mode == 0) ? 75 : (mode == 1) ? 65 : 65)) begin
          op = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
        end else if (r < 97) begin
          op = ($urandom_range(0, 1) != 0) ? CMD_SEARCH : CMD_UPDATE;
        end else begin
          op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        end
        add_cmd(op, pick_key(80), PRICE_W'($urandom()), (made % 350) == 349);
        made++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_to_send.size() != 0 || replies_due.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 20) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d results.", cmds_taken, replies_seen);
    $display("Status mix: %0d done, %0d empty, %0d not found, %0d full.",
             status_seen[ST_DONE], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
